// ===== src/pwv_pkg.sv =====
// pwv_pkg: shared types and constants for the protobuf wire validator
// parse phases, error codes, wire type codes and field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pwv_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int DATA_W          = 8;
	localparam int ERR_W           = 3;
	localparam int IDX_W           = 4;

	// last byte position of a ten byte varint
	localparam logic [IDX_W-1:0] VARINT_LAST_IDX = 4'd9;
	// tag bytes that still carry field number bits
	localparam logic [IDX_W-1:0] TAG_NZ_LAST_IDX = 4'd4;

	localparam int FIXED64_BYTES = 8;
	localparam int FIXED32_BYTES = 4;

	localparam logic [2:0] WIRE_VARINT  = 3'd0;
	localparam logic [2:0] WIRE_FIXED64 = 3'd1;
	localparam logic [2:0] WIRE_LEN     = 3'd2;
	localparam logic [2:0] WIRE_FIXED32 = 3'd5;

	typedef enum logic [2:0] {
		PH_TAG     = 3'd0,
		PH_VARVAL  = 3'd1,
		PH_FIXED   = 3'd2,
		PH_LENPFX  = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE     = 3'd0,
		ERR_VARINT   = 3'd1,
		ERR_FIELD0   = 3'd2,
		ERR_WIRETYPE = 3'd3,
		ERR_TRUNC    = 3'd4
	} err_t;

endpackage

`default_nettype wire

// ===== src/protobuf_wire_validator_unit.sv =====
// protobuf wire format validator, top level
// single pass parser: input register, parse logic, verdict register
// depends on pwv_pkg
`timescale 1ns / 1ps
`default_nettype none

// usage
// input channel: one message byte per transaction (data_byte), last_byte
//   high on the final byte of a message; in_valid / in_stall handshake
// output channel: one verdict transaction per message (well_formed,
//   error_kind); out_valid / out_stall handshake
// throughput: one byte per cycle while in_stall is low, set by the single pass
//   parse logic between the input register and the verdict register
// verdict path: the final byte goes through the input register, then the verdict register
// stall: while the verdict register is held by out_stall, non-final bytes
//   keep flowing in; a final byte waits in the input register and raises
//   in_stall until the held verdict is taken
// reset: arst_n clears the parser to expect a tag with no error latched
//   and empties both registers; after each verdict the parser clears itself
// LENGTH_BITS sets the length counter; longer length prefixes saturate and
//   report truncation

module protobuf_wire_validator_unit #(
	parameter int LENGTH_BITS = pwv_pkg::LENGTH_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [pwv_pkg::DATA_W-1:0] data_byte,
	input  logic                       last_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       well_formed,
	output logic [pwv_pkg::ERR_W-1:0]  error_kind
);
	import pwv_pkg::*;

	localparam int SUM_W = LENGTH_BITS + 7;
	localparam logic [LENGTH_BITS:0] ACC_SAT = {1'b1, {LENGTH_BITS{1'b0}}};

	logic                   s1_v_q;
	logic [DATA_W-1:0]      byte_s1;
	logic                   last_s1;
	logic                   proc;
	logic                   in_take;

	phase_t                 ph_q, ph_n;
	logic [IDX_W-1:0]       k_q, k_n;
	logic                   nz_q, nz_n;
	logic [LENGTH_BITS:0]   acc_q, acc_n;
	logic [LENGTH_BITS-1:0] skip_q, skip_n;
	err_t                   err_q, err_n;
	err_t                   verdict;

	logic                   out_v_q;
	logic                   wf_q;
	logic [ERR_W-1:0]       ek_q;

	logic [6:0]             lo7;
	logic                   cont;
	logic                   v_bad;
	logic                   v_done;
	logic [IDX_W-1:0]       k_step;
	logic                   nz_tag;
	logic [2:0]             wt;
	logic [6:0]             shift;
	logic [SUM_W-1:0]       sum;
	logic [LENGTH_BITS:0]   acc_add;
	logic [LENGTH_BITS-1:0] skip_dec;

	// handshake
	assign proc     = s1_v_q && (!last_s1 || !out_v_q || !out_stall);
	assign in_stall = s1_v_q && !proc;
	assign in_take  = in_valid && !in_stall;

	assign out_valid   = out_v_q;
	assign well_formed = wf_q;
	assign error_kind  = ek_q;

	// varint byte check
	assign lo7    = byte_s1[6:0];
	assign cont   = byte_s1[7];
	assign v_bad  = ((k_q == VARINT_LAST_IDX) && (lo7 > 7'd1)) ||
			(cont && (k_q >= VARINT_LAST_IDX));
	assign v_done = !v_bad && !cont;
	assign k_step = v_done ? '0 : (v_bad ? k_q : k_q + IDX_W'(1));

	// tag field number and wire type
	assign nz_tag = nz_q | ((k_q == '0) ? (|byte_s1[6:3]) :
			((k_q <= TAG_NZ_LAST_IDX) && (|lo7)));
	assign wt     = (k_q == '0) ? byte_s1[2:0] : acc_q[2:0];

	// length prefix accumulation, saturating
	assign shift = 7'(k_q) * 7'd7;
	assign sum   = SUM_W'(acc_q) + (SUM_W'(lo7) << shift[5:0]);

	always_comb begin
		if (lo7 == '0) begin
			acc_add = acc_q;
		end else if (shift >= 7'(LENGTH_BITS) || (|sum[SUM_W-1:LENGTH_BITS])) begin
			acc_add = ACC_SAT;
		end else begin
			acc_add = sum[LENGTH_BITS:0];
		end
	end

	assign skip_dec = (skip_q != '0) ? skip_q - LENGTH_BITS'(1) : skip_q;

	always_comb begin
		ph_n   = ph_q;
		k_n    = k_q;
		nz_n   = nz_q;
		acc_n  = acc_q;
		skip_n = skip_q;
		err_n  = err_q;
		if (err_q == ERR_NONE) begin
			unique case (ph_q) inside
				PH_TAG: begin
					nz_n  = nz_tag;
					acc_n = (k_q == '0) ? (LENGTH_BITS + 1)'(byte_s1[2:0]) : acc_q;
					k_n   = k_step;
					if (v_bad) begin
						err_n = ERR_VARINT;
					end else if (v_done) begin
						acc_n = '0;
						if (!nz_tag) begin
							err_n = ERR_FIELD0;
						end else begin
							nz_n = 1'b0;
							unique case (wt)
								WIRE_VARINT: begin
									ph_n = PH_VARVAL;
								end
								WIRE_FIXED64: begin
									skip_n = LENGTH_BITS'(FIXED64_BYTES);
									ph_n   = PH_FIXED;
								end
								WIRE_FIXED32: begin
									skip_n = LENGTH_BITS'(FIXED32_BYTES);
									ph_n   = PH_FIXED;
								end
								WIRE_LEN: begin
									ph_n = PH_LENPFX;
								end
								default: begin
									err_n = ERR_WIRETYPE;
								end
							endcase
						end
					end
				end
				PH_VARVAL: begin
					k_n = k_step;
					if (v_bad) begin
						err_n = ERR_VARINT;
					end else if (v_done) begin
						ph_n = PH_TAG;
					end
				end
				PH_LENPFX: begin
					k_n = k_step;
					if (v_bad) begin
						err_n = ERR_VARINT;
					end else begin
						acc_n = acc_add;
						if (v_done) begin
							if (acc_add[LENGTH_BITS]) begin
								err_n = ERR_TRUNC;
							end else if (acc_add == '0) begin
								ph_n = PH_TAG;
							end else begin
								skip_n = acc_add[LENGTH_BITS-1:0];
								ph_n   = PH_PAYLOAD;
							end
							acc_n = '0;
						end
					end
				end
				PH_FIXED, PH_PAYLOAD: begin
					skip_n = skip_dec;
					if (skip_dec == '0) begin
						ph_n = PH_TAG;
					end
				end
				default: begin
					ph_n = PH_TAG;
				end
			endcase
		end

		if (err_n == ERR_NONE && (ph_n != PH_TAG || k_n != '0)) begin
			verdict = ERR_TRUNC;
		end else begin
			verdict = err_n;
		end

		// message end clears the parser
		if (last_s1) begin
			ph_n   = PH_TAG;
			k_n    = '0;
			nz_n   = 1'b0;
			acc_n  = '0;
			skip_n = '0;
			err_n  = ERR_NONE;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_take) begin
			s1_v_q <= 1'b1;
		end else if (proc) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_TAG;
			k_q    <= '0;
			nz_q   <= 1'b0;
			acc_q  <= '0;
			skip_q <= '0;
			err_q  <= ERR_NONE;
		end else if (proc) begin
			ph_q   <= ph_n;
			k_q    <= k_n;
			nz_q   <= nz_n;
			acc_q  <= acc_n;
			skip_q <= skip_n;
			err_q  <= err_n;
		end
	end

	// verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (proc && last_s1) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			wf_q <= (verdict == ERR_NONE);
			ek_q <= verdict;
		end
	end

endmodule

`default_nettype wire

// ===== src/pwv_checker.sv =====
// pwv_checker: port level assertions for the protobuf wire validator
// bound to protobuf_wire_validator_unit; depends on pwv_pkg
`timescale 1ns / 1ps
`default_nettype none

module pwv_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       well_formed,
	input logic [pwv_pkg::ERR_W-1:0]  error_kind
);
	import pwv_pkg::*;

	// held verdict stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("verdict dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(well_formed) && $stable(error_kind))
		else $error("verdict changed while stalled");

	// flag and code agree
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (well_formed == (error_kind == ERR_NONE)))
		else $error("well_formed disagrees with error_kind");

	// input only stalls behind a held verdict
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held verdict");

	// a verdict needs a transaction in flight before it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid, 2) || $past(in_stall, 1) || $past(in_valid, 1))
		else $error("verdict without input");

endmodule

bind protobuf_wire_validator_unit pwv_checker u_pwv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.well_formed (well_formed),
	.error_kind  (error_kind)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for protobuf_wire_validator_unit
// directed byte table, then random messages checked against a wire parser model
// depends on pwv_pkg and protobuf_wire_validator_unit
`timescale 1ns / 1ps

module tb_top;
	import pwv_pkg::*;

	localparam int LEN_BITS = LENGTH_BITS_DEF;
	localparam logic [63:0] LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;
	localparam int RANDOM_BYTES = 1300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int DIR_N = 25;

	typedef enum logic [1:0] {
		VS_MORE,
		VS_DONE,
		VS_BAD
	} vstep_t;

	typedef struct packed {
		logic [7:0] dbyte;
		logic       last;
		logic       typed;
		logic       wf;
		err_t       ek;
	} dir_row_t;

	typedef struct packed {
		logic       wf;
		logic [2:0] ek;
	} verdict_t;

	localparam dir_row_t DIR_ROWS [0:DIR_N-1] = '{
		'{8'h08, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'h96, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'h01, 1'b1, 1'b1, 1'b1, ERR_NONE},
		'{8'h00, 1'b1, 1'b1, 1'b0, ERR_FIELD0},
		'{8'h0B, 1'b1, 1'b1, 1'b0, ERR_WIRETYPE},
		'{8'hFF, 1'b1, 1'b1, 1'b0, ERR_TRUNC},
		'{8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'h08, 1'b1, 1'b1, 1'b0, ERR_FIELD0},
		'{8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'hFF, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'h02, 1'b1, 1'b1, 1'b0, ERR_VARINT},
		'{8'h12, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'h80, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'h80, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'h04, 1'b1, 1'b1, 1'b0, ERR_TRUNC},
		'{8'h1A, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'h01, 1'b0, 1'b0, 1'b0, ERR_NONE},
		'{8'h7F, 1'b1, 1'b0, 1'b0, ERR_NONE}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'd0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       well_formed;
	logic [2:0] error_kind;

	protobuf_wire_validator_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.well_formed (well_formed),
		.error_kind  (error_kind)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// wire parser model state
	phase_t              wp_phase;
	logic [3:0]          wp_idx;
	bit                  wp_nz;
	logic [63:0]         wp_acc;
	logic [LEN_BITS-1:0] wp_skip;
	err_t                wp_err;

	verdict_t   verdict_q [$];
	logic [7:0] msg_q [$];
	int         fail_count = 0;
	int         byte_count = 0;
	int         msg_count = 0;
	int         idle_cycles = 0;
	int         stall_left = 0;
	bit         quiet = 1'b0;

	task wire_reset();
		wp_phase = PH_TAG;
		wp_idx = 4'd0;
		wp_nz = 1'b0;
		wp_acc = 64'd0;
		wp_skip = '0;
		wp_err = ERR_NONE;
	endtask

	task varint_advance(input logic [7:0] b, output vstep_t r);
		int sh;
		sh = 7 * wp_idx;
		if (sh == 63 && b[6:0] > 7'd1) begin
			r = VS_BAD;
		end else if (!b[7]) begin
			wp_idx = 4'd0;
			r = VS_DONE;
		end else if (sh + 7 > 63) begin
			r = VS_BAD;
		end else begin
			wp_idx = wp_idx + 4'd1;
			r = VS_MORE;
		end
	endtask

	task tag_finish();
		logic [2:0] wt;
		wt = wp_acc[2:0];
		wp_acc = 64'd0;
		if (!wp_nz) begin
			wp_err = ERR_FIELD0;
		end else begin
			wp_nz = 1'b0;
			case (wt)
				WIRE_VARINT: wp_phase = PH_VARVAL;
				WIRE_FIXED64: begin
					wp_skip = LEN_BITS'(FIXED64_BYTES);
					wp_phase = PH_FIXED;
				end
				WIRE_FIXED32: begin
					wp_skip = LEN_BITS'(FIXED32_BYTES);
					wp_phase = PH_FIXED;
				end
				WIRE_LEN: wp_phase = PH_LENPFX;
				default: wp_err = ERR_WIRETYPE;
			endcase
		end
	endtask

	task automatic wire_parse(input logic [7:0] b, input logic l, output bit got,
			output logic wf, output logic [2:0] ek);
		logic [3:0]  k;
		vstep_t      r;
		logic [63:0] part;
		int          sh;
		err_t        v;
		got = 1'b0;
		wf = 1'b0;
		ek = 3'd0;
		if (wp_err == ERR_NONE) begin
			k = wp_idx;
			case (wp_phase)
				PH_TAG: begin
					if (k == 4'd0) begin
						wp_acc = {61'd0, b[2:0]};
						if (b[6:3] != 4'd0)
							wp_nz = 1'b1;
					end else if (k <= TAG_NZ_LAST_IDX && b[6:0] != 7'd0) begin
						wp_nz = 1'b1;
					end
					varint_advance(b, r);
					if (r == VS_BAD)
						wp_err = ERR_VARINT;
					else if (r == VS_DONE)
						tag_finish();
				end
				PH_VARVAL: begin
					varint_advance(b, r);
					if (r == VS_BAD)
						wp_err = ERR_VARINT;
					else if (r == VS_DONE)
						wp_phase = PH_TAG;
				end
				PH_LENPFX: begin
					sh = 7 * k;
					part = {57'd0, b[6:0]};
					varint_advance(b, r);
					if (r == VS_BAD) begin
						wp_err = ERR_VARINT;
					end else begin
						if (part != 64'd0) begin
							if (sh >= LEN_BITS) begin
								wp_acc = LEN_MAX + 64'd1;
							end else begin
								wp_acc = wp_acc + (part << sh);
								if (wp_acc > LEN_MAX)
									wp_acc = LEN_MAX + 64'd1;
							end
						end
						if (r == VS_DONE) begin
							if (wp_acc > LEN_MAX) begin
								wp_err = ERR_TRUNC;
							end else if (wp_acc == 64'd0) begin
								wp_phase = PH_TAG;
							end else begin
								wp_skip = wp_acc[LEN_BITS-1:0];
								wp_phase = PH_PAYLOAD;
							end
							wp_acc = 64'd0;
						end
					end
				end
				PH_FIXED, PH_PAYLOAD: begin
					if (wp_skip != '0)
						wp_skip = wp_skip - LEN_BITS'(1);
					if (wp_skip == '0)
						wp_phase = PH_TAG;
				end
				default: wp_phase = PH_TAG;
			endcase
		end
		if (l) begin
			v = wp_err;
			if (v == ERR_NONE && (wp_phase != PH_TAG || wp_idx != 4'd0))
				v = ERR_TRUNC;
			got = 1'b1;
			wf = (v == ERR_NONE);
			ek = v;
			wire_reset();
		end
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// one input transaction, predicted at acceptance
	task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
			input logic twf, input logic [2:0] tek);
		bit         got;
		logic       wf;
		logic [2:0] ek;
		int         n;
		verdict_t   v;
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		byte_count++;
		wire_parse(b, l, got, wf, ek);
		if (got) begin
			v.wf = typed ? twf : wf;
			v.ek = typed ? tek : ek;
			verdict_q.push_back(v);
		end
		n = idle_len();
		if (n != 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic push_varint(input logic [63:0] v, input int min_len);
		int          n;
		int          i;
		logic [63:0] t;
		n = 1;
		t = v >> 7;
		while (t != 64'd0) begin
			n++;
			t = t >> 7;
		end
		if (min_len > n)
			n = min_len;
		t = v;
		for (i = 0; i < n; i++) begin
			msg_q.push_back({(i != n - 1), t[6:0]});
			t = t >> 7;
		end
	endtask

	function automatic int rand_pad();
		return ($urandom_range(0, 99) < 85) ? 1 : $urandom_range(1, 10);
	endfunction

	function automatic logic [31:0] rand_field_num();
		return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 15)
			: $urandom_range(1, 32'hFFFF_FFFF);
	endfunction

	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 127);
			1: return $urandom_range(0, 65535);
			2: return {$urandom, $urandom};
			default: return {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
	endfunction

	task automatic push_tag(input logic [31:0] fn, input logic [2:0] wt);
		push_varint(({32'd0, fn} << 3) | {61'd0, wt}, rand_pad());
	endtask

	task automatic push_random(input int n);
		repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_good_field();
		logic [2:0] wt;
		int         n;
		case ($urandom_range(0, 3))
			0: wt = WIRE_VARINT;
			1: wt = WIRE_FIXED64;
			2: wt = WIRE_LEN;
			default: wt = WIRE_FIXED32;
		endcase
		push_tag(rand_field_num(), wt);
		case (wt)
			WIRE_VARINT: push_varint(rand_value(), rand_pad());
			WIRE_FIXED64: push_random(FIXED64_BYTES);
			WIRE_FIXED32: push_random(FIXED32_BYTES);
			default: begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
					: $urandom_range(0, 6);
				push_varint(64'(n), rand_pad());
				push_random(n);
			end
		endcase
	endtask

	task automatic add_broken_field();
		logic [2:0]  wt;
		logic [63:0] hi;
		case ($urandom_range(0, 6))
			0: begin
				wt = 3'($urandom_range(3, 7));
				if (wt == WIRE_FIXED32)
					wt = 3'd6;
				push_tag(rand_field_num(), wt);
				push_random($urandom_range(0, 4));
			end
			1: begin
				// field number only above tag bit 34, or none at all
				hi = $urandom_range(0, 1) ? ({$urandom, $urandom} << 35) : 64'd0;
				push_varint(hi | $urandom_range(0, 7), rand_pad());
				push_random($urandom_range(0, 2));
			end
			2: begin
				push_tag(rand_field_num(), WIRE_VARINT);
				repeat (10) msg_q.push_back(8'($urandom_range(128, 255)));
				push_random(1);
			end
			3: begin
				push_tag(rand_field_num(), WIRE_VARINT);
				repeat (9) msg_q.push_back(8'($urandom_range(128, 255)));
				msg_q.push_back(8'($urandom_range(0, 1) ? $urandom_range(130, 255)
					: $urandom_range(2, 127)));
			end
			4: begin
				push_tag(rand_field_num(), WIRE_LEN);
				hi = $urandom_range(0, 1) ? {$urandom, $urandom}
					: $urandom_range(0, 100000);
				push_varint(hi | 64'h1_0000, rand_pad());
				push_random($urandom_range(0, 3));
			end
			5: begin
				push_tag(rand_field_num(), WIRE_LEN);
				push_varint(64'($urandom_range(100, 65535)), 1);
				push_random($urandom_range(0, 5));
			end
			default: push_random($urandom_range(1, 8));
		endcase
	endtask

	task automatic build_message();
		msg_q.delete();
		repeat ($urandom_range(0, 3)) add_good_field();
		if ($urandom_range(0, 3) == 0)
			add_broken_field();
		if ($urandom_range(0, 2) == 0)
			add_good_field();
		if (msg_q.size() == 0)
			add_good_field();
		if ($urandom_range(0, 7) == 0 && msg_q.size() > 1)
			repeat ($urandom_range(1, msg_q.size() - 1)) void'(msg_q.pop_back());
	endtask

	always @(posedge clk) begin : stall_gen
		int n;
		if (quiet) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			n = idle_len();
			out_stall <= (n != 0);
			stall_left <= n;
		end
	end

	always @(posedge clk) begin : verdict_check
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected verdict, got well_formed %0b error_kind %0d",
					$time, well_formed, error_kind);
				fail_count++;
			end else begin
				want = verdict_q.pop_front();
				if (well_formed !== want.wf) begin
					$display("%0t: well_formed mismatch, expected %0b, got %0b",
						$time, want.wf, well_formed);
					fail_count++;
				end
				if (error_kind !== want.ek) begin
					$display("%0t: error_kind mismatch, expected %0d, got %0d",
						$time, want.ek, error_kind);
					fail_count++;
				end
			end
		end
	end

	// cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int i;
		wire_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (i = 0; i < DIR_N; i++)
			send_byte(DIR_ROWS[i].dbyte, DIR_ROWS[i].last, DIR_ROWS[i].typed,
				DIR_ROWS[i].wf, DIR_ROWS[i].ek);
		while (byte_count < DIR_N + RANDOM_BYTES) begin
			quiet <= ((msg_count % 37) < 5);
			build_message();
			for (i = 0; i < msg_q.size(); i++)
				send_byte(msg_q[i], (i == msg_q.size() - 1), 1'b0, 1'b0, ERR_NONE);
			msg_count++;
			// sender holds off until the output side drains
			if (msg_count == 25 || msg_count == 70) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (verdict_q.size() != 0)
					@(posedge clk);
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== protobuf_wire_validator_unit.f =====
src/pwv_pkg.sv
src/protobuf_wire_validator_unit.sv
src/pwv_checker.sv
test/tb_top.sv
